// ===== rtl/image_header_stream_parser_assert.svh =====
// assertion macros shared by the size check and parse core modules of the image header stream parser
`ifndef IMAGE_HEADER_STREAM_PARSER_ASSERT_SVH
`define IMAGE_HEADER_STREAM_PARSER_ASSERT_SVH

// clocked check, off while reset is held
`ifndef ASSERT_OFF
`define IHSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`else
`define IHSP_ASSERT(label, prop, msg)
`endif

// clocked check that also holds during reset
`ifndef ASSERT_OFF
`define IHSP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define IHSP_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/ihsp_pkg.sv =====
// types, codes and constants of the image header stream parser
package ihsp_pkg;

    localparam int PHASE_W = 4;
    localparam int CLASS_W = 4;
    localparam int ERR_W   = 3;
    localparam int TAG_W   = 16;
    localparam int CH_W    = 2;
    localparam int FIELD_W = 64;
    localparam int BYTE_W  = 8;

    // parse phases; the numeric field phases share their code with the byte class
    localparam logic [PHASE_W-1:0] PH_MAGIC    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_HDRSIZE  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_CONTSIZE = 4'd2;
    localparam logic [PHASE_W-1:0] PH_WIDTH    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_HEIGHT   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_CAPTION  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_TAGS     = 4'd7;
    localparam logic [PHASE_W-1:0] PH_PIXEL    = 4'd9;
    localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd10;

    // byte classes
    localparam logic [CLASS_W-1:0] CLS_MAGIC    = 4'd0;
    localparam logic [CLASS_W-1:0] CLS_CAPTION  = 4'd5;
    localparam logic [CLASS_W-1:0] CLS_CAP_END  = 4'd6;
    localparam logic [CLASS_W-1:0] CLS_TAG      = 4'd7;
    localparam logic [CLASS_W-1:0] CLS_TAG_END  = 4'd8;
    localparam logic [CLASS_W-1:0] CLS_PIXEL    = 4'd9;
    localparam logic [CLASS_W-1:0] CLS_IGNORED  = 4'd10;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_MAGIC = 3'd1;
    localparam logic [ERR_W-1:0] ERR_SIZE      = 3'd2;
    localparam logic [ERR_W-1:0] ERR_SHORT     = 3'd3;
    localparam logic [ERR_W-1:0] ERR_CAPTION   = 3'd4;

    localparam logic [FIELD_W-1:0] HDR_FIXED_LEN = 64'd36;
    localparam logic [BYTE_W-1:0]  CHAR_NEWLINE  = 8'h0A;
    localparam logic [BYTE_W-1:0]  CHAR_NUL      = 8'h00;
    localparam logic [TAG_W-1:0]   TAG_MAX       = 16'hFFFF;
    localparam logic [CH_W-1:0]    CH_BLUE       = 2'd2;
    localparam logic [2:0]         FIELD_LAST_IDX = 3'd7;
    localparam logic [1:0]         MAGIC_LAST_IDX = 2'd3;

    // three times the width needs two extra bits, one height byte adds eight
    localparam int TW_W   = FIELD_W + 2;
    localparam int PROD_W = TW_W + BYTE_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int CARRY_W = SUM_W - BYTE_W;

    typedef struct packed {
        logic               width_load;
        logic               height_step;
        logic [2:0]         byte_idx;
    } chk_ctl_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  byte_out;
        logic [CLASS_W-1:0] byte_class;
        logic [TAG_W-1:0]   tag_number;
        logic [CH_W-1:0]    color_channel;
        logic [FIELD_W-1:0] field_value;
        logic               field_done;
        logic [ERR_W-1:0]   error_code;
        logic               image_done;
    } res_t;

    function automatic logic [BYTE_W-1:0] magic_byte(input logic [1:0] idx);
        logic [BYTE_W-1:0] r;
        unique case (idx)
            2'd0:    r = 8'h43;
            2'd1:    r = 8'h49;
            default: r = 8'h46;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/image_header_stream_parser.sv =====
// top level of the image header stream parser
//
//  channel  dir  handshake          tdata / tuser / tlast
//  s_       in   s_tvalid/s_tready  data_byte / first_byte / -
//  m_       out  m_tvalid/m_tready  see m_tdata / byte_class / image_done
//
// one item in, one item out; every cycle an item may enter unless a held result is stalled by m_tready low
// an accepted item is registered and shows at m_ on the next cycle
// the critical path is the 66x8 partial product and carry add of the size check
// reset is synchronous on aresetn low and returns the parse to the magic bytes
// s_tready drops only while a held result is stalled by m_tready low
module image_header_stream_parser (
    input  logic         aclk,
    input  logic         aresetn,
    // slave side
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic [0:0]   s_tuser,   // [0] first_byte
    // master side
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // [7:0] byte_out, [23:8] tag_number,
                                    // [25:24] color_channel, [89:26] field_value,
                                    // [90] field_done, [93:91] error_code, [95:94] zero
    output logic [3:0]   m_tuser,   // [3:0] byte_class
    output logic         m_tlast    // image_done
);

    logic           item_acc;
    ihsp_pkg::res_t res_now;
    ihsp_pkg::res_t res_held;

    // an item is taken when both handshake lines are high
    assign item_acc = s_tvalid && s_tready;

    // classification and parse state
    ihsp_parse_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_acc   (item_acc),
        .data_byte  (s_tdata),
        .first_byte (s_tuser[0]),
        .res        (res_now)
    );

    // result register
    ihsp_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_acc  (item_acc),
        .res_in    (res_now),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .in_ready  (s_tready),
        .res_out   (res_held)
    );

    // pack the result fields, highest field first
    assign m_tdata = {2'b00,
                      res_held.error_code,
                      res_held.field_done,
                      res_held.field_value,
                      res_held.color_channel,
                      res_held.tag_number,
                      res_held.byte_out};
    assign m_tuser = res_held.byte_class;
    assign m_tlast = res_held.image_done;

endmodule

// ===== rtl/ihsp_size_chk.sv =====
// content size check: three times width times height, built one height byte a cycle while items are accepted
`include "image_header_stream_parser_assert.svh"
module ihsp_size_chk (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ihsp_pkg::chk_ctl_t             ctl,
    input  logic [ihsp_pkg::FIELD_W-1:0]   width_val,
    input  logic [ihsp_pkg::BYTE_W-1:0]    height_byte,
    input  logic [ihsp_pkg::FIELD_W-1:0]   cont_len,
    output logic                           size_ok
);

    logic [ihsp_pkg::TW_W-1:0]    tw_reg;
    logic [ihsp_pkg::CARRY_W-1:0] carry_reg;
    logic [ihsp_pkg::CARRY_W-1:0] carry_cur;
    logic                         mis_reg;
    logic                         mis_next;
    logic [ihsp_pkg::PROD_W-1:0]  prod;
    logic [ihsp_pkg::SUM_W-1:0]   sum;
    logic [ihsp_pkg::BYTE_W-1:0]  cont_byte;

    // partial product of this byte plus what carried over from lower bytes
    assign carry_cur = (ctl.byte_idx == 3'd0) ? '0 : carry_reg;
    assign prod      = tw_reg * {{(ihsp_pkg::TW_W-ihsp_pkg::BYTE_W){1'b0}}, height_byte};
    assign sum       = {{(ihsp_pkg::SUM_W-ihsp_pkg::CARRY_W){1'b0}}, carry_cur}
                     + {1'b0, prod};
    assign cont_byte = cont_len[{ctl.byte_idx, 3'b000} +: ihsp_pkg::BYTE_W];
    assign mis_next  = (sum[ihsp_pkg::BYTE_W-1:0] != cont_byte)
                     || ((ctl.byte_idx != 3'd0) && mis_reg);
    // anything left above bit 63 is an overflow
    assign size_ok   = !mis_next && (sum[ihsp_pkg::SUM_W-1:ihsp_pkg::BYTE_W] == '0);

    always_ff @(posedge aclk) begin
        if (ctl.width_load) begin
            tw_reg <= {2'b00, width_val} + {1'b0, width_val, 1'b0};
        end
        if (ctl.height_step) begin
            carry_reg <= sum[ihsp_pkg::SUM_W-1:ihsp_pkg::BYTE_W];
            mis_reg   <= mis_next;
        end
    end

    `IHSP_ASSERT(a_no_load_in_height, !(ctl.width_load && ctl.height_step), "width load during height")
    `IHSP_ASSERT(a_height_bytes_in_order, ctl.height_step && ctl.byte_idx != ihsp_pkg::FIELD_LAST_IDX |=> !ctl.width_load, "width load right after height byte")
    `IHSP_ASSERT(a_load_on_last_byte, ctl.width_load |-> ctl.byte_idx == ihsp_pkg::FIELD_LAST_IDX, "width load before its last byte")

endmodule

// ===== rtl/ihsp_parse_core.sv =====
// parse state and byte classification for one accepted item
`include "image_header_stream_parser_assert.svh"
module ihsp_parse_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_acc,
    input  logic [ihsp_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          first_byte,
    output ihsp_pkg::res_t                res
);

    logic [ihsp_pkg::PHASE_W-1:0] phase_reg, phase_next, cur_phase;
    logic [ihsp_pkg::FIELD_W-1:0] off_reg, cur_off, off_inc;
    logic [ihsp_pkg::FIELD_W-1:0] acc_reg, acc_cur, fv;
    logic [ihsp_pkg::FIELD_W-1:0] hdr_len_reg, cont_len_reg, pix_end_reg;
    logic [ihsp_pkg::TAG_W-1:0]   tag_reg, tag_next, cur_tag;
    logic [ihsp_pkg::CH_W-1:0]    ch_reg, ch_next, cur_ch;
    logic [ihsp_pkg::ERR_W-1:0]   err_reg, err_next, cur_err;
    logic [2:0]                   k;
    logic                         last_hdr, last_pix, size_ok;
    ihsp_pkg::chk_ctl_t           chk_ctl;
    ihsp_pkg::res_t               r;

    // a first byte restarts the parse before it is classified
    assign cur_phase = first_byte ? ihsp_pkg::PH_MAGIC : phase_reg;
    assign cur_off   = first_byte ? '0 : off_reg;
    assign cur_tag   = first_byte ? '0 : tag_reg;
    assign cur_ch    = first_byte ? '0 : ch_reg;
    assign cur_err   = first_byte ? ihsp_pkg::ERR_NONE : err_reg;

    assign off_inc  = cur_off + 64'd1;
    assign last_hdr = (off_inc == hdr_len_reg);
    assign last_pix = (off_inc == pix_end_reg);

    // field byte index; fields start at offset 4
    assign k       = cur_off[2:0] ^ 3'b100;
    assign acc_cur = (k == 3'd0) ? '0 : acc_reg;
    assign fv      = acc_cur | ({56'd0, data_byte} << {k, 3'b000});

    assign chk_ctl.width_load  = item_acc && (cur_phase == ihsp_pkg::PH_WIDTH)
                                 && (k == ihsp_pkg::FIELD_LAST_IDX);
    assign chk_ctl.height_step = item_acc && (cur_phase == ihsp_pkg::PH_HEIGHT);
    assign chk_ctl.byte_idx    = k;

    ihsp_size_chk u_size_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (chk_ctl),
        .width_val   (fv),
        .height_byte (data_byte),
        .cont_len    (cont_len_reg),
        .size_ok     (size_ok)
    );

    always_comb begin
        r            = '0;
        r.byte_out   = data_byte;
        r.byte_class = ihsp_pkg::CLS_IGNORED;
        phase_next   = cur_phase;
        tag_next     = cur_tag;
        ch_next      = cur_ch;
        err_next     = cur_err;
        unique case (cur_phase) inside
            ihsp_pkg::PH_MAGIC: begin
                r.byte_class = ihsp_pkg::CLS_MAGIC;
                if (data_byte != ihsp_pkg::magic_byte(cur_off[1:0])) begin
                    err_next     = ihsp_pkg::ERR_BAD_MAGIC;
                    r.image_done = 1'b1;
                    phase_next   = ihsp_pkg::PH_IDLE;
                end else if (cur_off[1:0] == ihsp_pkg::MAGIC_LAST_IDX) begin
                    phase_next = ihsp_pkg::PH_HDRSIZE;
                end
            end
            ihsp_pkg::PH_HDRSIZE, ihsp_pkg::PH_CONTSIZE,
            ihsp_pkg::PH_WIDTH, ihsp_pkg::PH_HEIGHT: begin
                // field phase codes equal their byte class codes
                r.byte_class  = cur_phase;
                r.field_value = fv;
                if (k == ihsp_pkg::FIELD_LAST_IDX) begin
                    r.field_done = 1'b1;
                    if (cur_phase != ihsp_pkg::PH_HEIGHT) begin
                        phase_next = cur_phase + 4'd1;
                    end else begin
                        if (!size_ok) begin
                            err_next = ihsp_pkg::ERR_SIZE;
                        end else if (hdr_len_reg < ihsp_pkg::HDR_FIXED_LEN) begin
                            err_next = ihsp_pkg::ERR_SHORT;
                        end else if (hdr_len_reg == ihsp_pkg::HDR_FIXED_LEN) begin
                            err_next = ihsp_pkg::ERR_CAPTION;
                        end
                        if (err_next != ihsp_pkg::ERR_NONE) begin
                            r.image_done = 1'b1;
                            phase_next   = ihsp_pkg::PH_IDLE;
                        end else begin
                            phase_next = ihsp_pkg::PH_CAPTION;
                        end
                    end
                end
            end
            ihsp_pkg::PH_CAPTION: begin
                r.byte_class = ihsp_pkg::CLS_CAPTION;
                if (data_byte == ihsp_pkg::CHAR_NEWLINE) begin
                    r.byte_class = ihsp_pkg::CLS_CAP_END;
                    if (last_hdr) begin
                        if (cont_len_reg == '0) begin
                            phase_next   = ihsp_pkg::PH_IDLE;
                            r.image_done = 1'b1;
                        end else begin
                            phase_next = ihsp_pkg::PH_PIXEL;
                            ch_next    = '0;
                        end
                    end else begin
                        phase_next = ihsp_pkg::PH_TAGS;
                    end
                end else if (last_hdr) begin
                    err_next     = ihsp_pkg::ERR_CAPTION;
                    r.image_done = 1'b1;
                    phase_next   = ihsp_pkg::PH_IDLE;
                end
            end
            ihsp_pkg::PH_TAGS: begin
                r.byte_class = ihsp_pkg::CLS_TAG;
                r.tag_number = cur_tag;
                if (data_byte == ihsp_pkg::CHAR_NUL) begin
                    r.byte_class = ihsp_pkg::CLS_TAG_END;
                    if (cur_tag != ihsp_pkg::TAG_MAX) begin
                        tag_next = cur_tag + 16'd1;
                    end
                end
                if (last_hdr) begin
                    if (cont_len_reg == '0) begin
                        phase_next   = ihsp_pkg::PH_IDLE;
                        r.image_done = 1'b1;
                    end else begin
                        phase_next = ihsp_pkg::PH_PIXEL;
                        ch_next    = '0;
                    end
                end
            end
            ihsp_pkg::PH_PIXEL: begin
                r.byte_class    = ihsp_pkg::CLS_PIXEL;
                r.color_channel = cur_ch;
                ch_next         = (cur_ch >= ihsp_pkg::CH_BLUE) ? '0 : cur_ch + 2'd1;
                if (last_pix) begin
                    r.image_done = 1'b1;
                    phase_next   = ihsp_pkg::PH_IDLE;
                end
            end
            default: begin
                r.byte_class = ihsp_pkg::CLS_IGNORED;
            end
        endcase
        r.error_code = err_next;
    end

    assign res = r;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ihsp_pkg::PH_MAGIC;
            off_reg   <= '0;
            tag_reg   <= '0;
            ch_reg    <= '0;
            err_reg   <= ihsp_pkg::ERR_NONE;
        end else if (item_acc) begin
            phase_reg <= phase_next;
            off_reg   <= off_inc;
            tag_reg   <= tag_next;
            ch_reg    <= ch_next;
            err_reg   <= err_next;
        end
    end

    // header fields are always written before they are read again
    always_ff @(posedge aclk) begin
        if (item_acc) begin
            acc_reg <= (k == ihsp_pkg::FIELD_LAST_IDX) ? '0 : fv;
            if (r.field_done && cur_phase == ihsp_pkg::PH_HDRSIZE) begin
                hdr_len_reg <= fv;
            end
            if (r.field_done && cur_phase == ihsp_pkg::PH_CONTSIZE) begin
                cont_len_reg <= fv;
            end
        end
        pix_end_reg <= hdr_len_reg + cont_len_reg;
    end

    `IHSP_ASSERT(a_err_means_idle, err_reg != ihsp_pkg::ERR_NONE |-> phase_reg == ihsp_pkg::PH_IDLE, "error without idle phase")
    `IHSP_ASSERT(a_done_goes_idle, item_acc && r.image_done |=> phase_reg == ihsp_pkg::PH_IDLE, "image done but parse goes on")
    `IHSP_ASSERT(a_tag_saturates, item_acc && !first_byte && tag_reg == ihsp_pkg::TAG_MAX |=> tag_reg == ihsp_pkg::TAG_MAX, "tag counter wrapped")
    `IHSP_ASSERT_ALWAYS(a_channel_range, !aresetn || ch_reg != 2'd3, "color channel out of range")

endmodule

// ===== rtl/ihsp_out_reg.sv =====
// result register between the parse logic and the result channel
module ihsp_out_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            item_acc,
    input  ihsp_pkg::res_t  res_in,
    input  logic            out_ready,
    output logic            out_valid,
    output logic            in_ready,
    output ihsp_pkg::res_t  res_out
);

    logic           valid_reg;
    ihsp_pkg::res_t res_reg;

    // a new item may enter when no result is held or the held result leaves in the same cycle
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (item_acc) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_acc) begin
            res_reg <= res_in;
        end
    end

endmodule
